@@ design/pncm_pkg.sv @@
package pncm_pkg;

   localparam int DEFAULT_PALETTE_DEPTH     = 32;
   localparam int DEFAULT_HUE_FRACTION_BITS = 4;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_METRIC_MODE   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_COUNT = CSR_INDEX_W'(1);

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_MATCH = 1'b1;

   localparam logic METRIC_HUE = 1'b0;
   localparam logic METRIC_RGB = 1'b1;

   typedef struct packed {
      logic       op;
      logic [4:0] entry_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [4:0] match_index;
      logic [7:0] match_red;
      logic [7:0] match_green;
      logic [7:0] match_blue;
      logic       empty_palette;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH,
      ST_SCAN
   } state_type;

   typedef enum logic [1:0] {
      SEC_RED,
      SEC_GREEN,
      SEC_BLUE
   } sector_type;

endpackage

@@ design/palette_nearest_color_matcher.sv @@
// Hue-mode matches and loads compute the hue with a bit-serial divider, one quotient bit a cycle
// over Q = 6 + HUE_FRACTION_BITS bits, skipped for grey or black; RGB-mode matches skip it.
// Matches then scan the N entries in use with one palette read a cycle; an empty palette is
// answered without a scan, with empty_palette set. Loads give no result. busy stays high until
// a command is done, so a new command is taken only once the last one has finished.
// Sync active-high reset clears control state and CSRs only; receiver never stalls.
module palette_nearest_color_matcher #(
   parameter int PALETTE_DEPTH     = pncm_pkg::DEFAULT_PALETTE_DEPTH,
   parameter int HUE_FRACTION_BITS = pncm_pkg::DEFAULT_HUE_FRACTION_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  pncm_pkg::req_type                  req_item,
   output logic                               rsp_strobe,
   output pncm_pkg::rsp_type                  rsp_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pncm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pncm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W  = $clog2(PALETTE_DEPTH);
   localparam int SAT_W  = (IDX_W + 1 > 6) ? IDX_W + 1 : 6;
   localparam int HW     = 9 + HUE_FRACTION_BITS;
   localparam int QW     = 6 + HUE_FRACTION_BITS;
   localparam int NW     = QW + 8;
   localparam int STEP_W = $clog2(QW);
   localparam int DIST_W = (HW > 18) ? HW : 18;

   localparam logic [HW:0]   HUE_FULL = (HW+1)'(360 * (1 << HUE_FRACTION_BITS));
   localparam logic [HW-1:0] HUE_HALF = HW'(180 * (1 << HUE_FRACTION_BITS));
   localparam logic [HW:0]   HUE_120  = (HW+1)'(120 * (1 << HUE_FRACTION_BITS));
   localparam logic [HW:0]   HUE_240  = (HW+1)'(240 * (1 << HUE_FRACTION_BITS));
   localparam logic [NW-1:0] HUE_60   = NW'(60 * (1 << HUE_FRACTION_BITS));

   pncm_pkg::state_type  state_ff, state_in;
   pncm_pkg::req_type    item_ff, item_in;
   pncm_pkg::sector_type sector_ff, sector_in;
   pncm_pkg::rsp_type    rsp_item_ff, rsp_item_in;

   logic                metric_ff, metric_in;
   logic [5:0]          count_ff, count_in;
   logic                neg_ff, neg_in;
   logic                zero_ff, zero_in;
   logic [7:0]          div_ff, div_in;
   logic [7:0]          rem_ff, rem_in;
   logic [QW-1:0]       quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [HW-1:0]       hue_ff, hue_in;
   logic [IDX_W-1:0]    rd_addr_ff, rd_addr_in;
   logic                issue_ff, issue_in;
   logic                s1_valid_ff, s1_valid_in;
   logic [IDX_W-1:0]    s1_idx_ff, s1_idx_in;
   logic [23:0]         color_rd_ff;
   logic [HW-1:0]       hue_rd_ff;
   logic                s2_valid_ff, s2_valid_in;
   logic [IDX_W-1:0]    s2_idx_ff, s2_idx_in;
   logic [23:0]         s2_color_ff, s2_color_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   logic [DIST_W-1:0]   best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [23:0]         best_color_ff, best_color_in;
   logic                rsp_strobe_ff, rsp_strobe_in;

   logic [23:0]         color_mem [PALETTE_DEPTH];
   logic [HW-1:0]       hue_mem   [PALETTE_DEPTH];

   logic                accept;
   logic [SAT_W-1:0]    cnt_ext, cnt_sat;
   logic [IDX_W-1:0]    last_idx;
   logic                slot_ok;
   logic                mem_we, rd_en;
   logic                scan_done;
   logic                take_new;

   // hue setup
   logic [7:0]          mx, mn, d;
   pncm_pkg::sector_type sector;
   logic [8:0]          diff;
   logic [7:0]          mag;
   logic [NW-1:0]       num;
   logic [8:0]          trial;
   logic [HW:0]         h_acc;
   logic [HW-1:0]       hue_calc;

   // distances
   logic [HW-1:0]       hd_raw, hue_dist;
   logic [8:0]          dr, dg, db;
   logic [7:0]          ar, ag, ab;
   logic [DIST_W-1:0]   rgb_dist;

   assign accept    = start && !busy;
   assign busy      = (state_ff != pncm_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   assign cnt_ext  = SAT_W'(count_ff);
   assign cnt_sat  = (cnt_ext > SAT_W'(PALETTE_DEPTH)) ? SAT_W'(PALETTE_DEPTH) : cnt_ext;
   assign last_idx = IDX_W'(cnt_sat - SAT_W'(1));
   assign slot_ok  = (SAT_W'(item_ff.entry_index) < SAT_W'(PALETTE_DEPTH));
   assign scan_done = s2_valid_ff && (s2_idx_ff == last_idx);
   assign take_new  = s2_valid_ff && ((s2_idx_ff == '0) || (dist_ff < best_dist_ff));

   // max/min/sector of the latched color
   always_comb begin
      mx = item_ff.red;
      if (item_ff.green > mx) mx = item_ff.green;
      if (item_ff.blue > mx)  mx = item_ff.blue;
      mn = item_ff.red;
      if (item_ff.green < mn) mn = item_ff.green;
      if (item_ff.blue < mn)  mn = item_ff.blue;
      d = mx - mn;
      priority if (mx == item_ff.red) begin
         sector = pncm_pkg::SEC_RED;
         diff   = {1'b0, item_ff.green} - {1'b0, item_ff.blue};
      end else if (mx == item_ff.green) begin
         sector = pncm_pkg::SEC_GREEN;
         diff   = {1'b0, item_ff.blue} - {1'b0, item_ff.red};
      end else begin
         sector = pncm_pkg::SEC_BLUE;
         diff   = {1'b0, item_ff.red} - {1'b0, item_ff.green};
      end
      mag = diff[8] ? 8'(-diff) : diff[7:0];
      num = NW'(mag) * HUE_60;
   end

   // signed quotient plus sector offset, wrapped into one turn
   always_comb begin
      h_acc = neg_ff ? -((HW+1)'(quo_ff)) : (HW+1)'(quo_ff);
      unique case (sector_ff)
         pncm_pkg::SEC_GREEN: h_acc = h_acc + HUE_120;
         pncm_pkg::SEC_BLUE:  h_acc = h_acc + HUE_240;
         default:             h_acc = h_acc;
      endcase
      if (h_acc[HW]) h_acc = h_acc + HUE_FULL;
      hue_calc = zero_ff ? '0 : h_acc[HW-1:0];
   end

   always_comb begin
      hd_raw   = (hue_rd_ff > hue_ff) ? (hue_rd_ff - hue_ff) : (hue_ff - hue_rd_ff);
      hue_dist = (hd_raw > HUE_HALF) ? HW'(HUE_FULL - (HW+1)'(hd_raw)) : hd_raw;
      dr = {1'b0, color_rd_ff[23:16]} - {1'b0, item_ff.red};
      dg = {1'b0, color_rd_ff[15:8]}  - {1'b0, item_ff.green};
      db = {1'b0, color_rd_ff[7:0]}   - {1'b0, item_ff.blue};
      ar = dr[8] ? 8'(-dr) : dr[7:0];
      ag = dg[8] ? 8'(-dg) : dg[7:0];
      ab = db[8] ? 8'(-db) : db[7:0];
      rgb_dist = DIST_W'(ar) * DIST_W'(ar) + DIST_W'(ag) * DIST_W'(ag) +
                 DIST_W'(ab) * DIST_W'(ab);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pncm_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_item.op == pncm_pkg::OP_MATCH && cnt_sat == '0)
                  state_in = pncm_pkg::ST_IDLE;
               else
                  state_in = pncm_pkg::ST_SETUP;
            end
         end
         pncm_pkg::ST_SETUP: begin
            if (item_ff.op == pncm_pkg::OP_MATCH && metric_ff == pncm_pkg::METRIC_RGB)
               state_in = pncm_pkg::ST_SCAN;
            else if (d == '0)
               state_in = pncm_pkg::ST_FINISH;
            else
               state_in = pncm_pkg::ST_DIVIDE;
         end
         pncm_pkg::ST_DIVIDE: begin
            if (step_ff == '0) state_in = pncm_pkg::ST_FINISH;
         end
         pncm_pkg::ST_FINISH: begin
            if (item_ff.op == pncm_pkg::OP_LOAD)
               state_in = pncm_pkg::ST_IDLE;
            else
               state_in = pncm_pkg::ST_SCAN;
         end
         pncm_pkg::ST_SCAN: begin
            if (scan_done) state_in = pncm_pkg::ST_IDLE;
         end
         default: state_in = pncm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      item_in       = item_ff;
      metric_in     = metric_ff;
      count_in      = count_ff;
      sector_in     = sector_ff;
      neg_in        = neg_ff;
      zero_in       = zero_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      hue_in        = hue_ff;
      rd_addr_in    = rd_addr_ff;
      issue_in      = issue_ff;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      s1_valid_in   = 1'b0;
      s1_idx_in     = rd_addr_ff;
      s2_valid_in   = s1_valid_ff;
      s2_idx_in     = s1_idx_ff;
      s2_color_in   = color_rd_ff;
      dist_in       = (metric_ff == pncm_pkg::METRIC_RGB) ? rgb_dist : DIST_W'(hue_dist);
      best_dist_in  = best_dist_ff;
      best_idx_in   = best_idx_ff;
      best_color_in = best_color_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      trial         = {rem_ff, quo_ff[QW-1]};

      if (csr_valid && csr_ready) begin
         priority if (csr_index == pncm_pkg::CSR_METRIC_MODE)
            metric_in = csr_wdata[0];
         else if (csr_index == pncm_pkg::CSR_PALETTE_COUNT)
            count_in = csr_wdata[5:0];
         else begin
            // no register behind this index
         end
      end

      unique case (state_ff)
         pncm_pkg::ST_IDLE: begin
            if (accept) begin
               item_in = req_item;
               if (req_item.op == pncm_pkg::OP_MATCH && cnt_sat == '0) begin
                  rsp_strobe_in             = 1'b1;
                  rsp_item_in.match_index   = '0;
                  rsp_item_in.match_red     = '0;
                  rsp_item_in.match_green   = '0;
                  rsp_item_in.match_blue    = '0;
                  rsp_item_in.empty_palette = 1'b1;
               end
            end
         end
         pncm_pkg::ST_SETUP: begin
            sector_in  = sector;
            neg_in     = diff[8];
            zero_in    = (d == '0);
            div_in     = d;
            // top bits are below d since the quotient fits in QW bits
            rem_in     = num[NW-1:QW];
            quo_in     = num[QW-1:0];
            step_in    = STEP_W'(QW - 1);
            rd_addr_in = '0;
            issue_in   = 1'b1;
         end
         pncm_pkg::ST_DIVIDE: begin
            if (trial >= {1'b0, div_ff}) begin
               rem_in = 8'(trial - {1'b0, div_ff});
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = trial[7:0];
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
         end
         pncm_pkg::ST_FINISH: begin
            hue_in = hue_calc;
            mem_we = (item_ff.op == pncm_pkg::OP_LOAD) && slot_ok;
         end
         pncm_pkg::ST_SCAN: begin
            rd_en       = issue_ff;
            s1_valid_in = issue_ff;
            if (issue_ff) begin
               if (rd_addr_ff == last_idx)
                  issue_in = 1'b0;
               else
                  rd_addr_in = rd_addr_ff + 1'b1;
            end
            if (take_new) begin
               best_dist_in  = dist_ff;
               best_idx_in   = s2_idx_ff;
               best_color_in = s2_color_ff;
            end
            if (scan_done) begin
               rsp_strobe_in             = 1'b1;
               rsp_item_in.match_index   = take_new ? 5'(s2_idx_ff) : 5'(best_idx_ff);
               rsp_item_in.match_red     = take_new ? s2_color_ff[23:16] : best_color_ff[23:16];
               rsp_item_in.match_green   = take_new ? s2_color_ff[15:8] : best_color_ff[15:8];
               rsp_item_in.match_blue    = take_new ? s2_color_ff[7:0] : best_color_ff[7:0];
               rsp_item_in.empty_palette = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pncm_pkg::ST_IDLE;
         metric_ff     <= pncm_pkg::METRIC_HUE;
         count_ff      <= '0;
         issue_ff      <= 1'b0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         metric_ff     <= metric_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      sector_ff     <= sector_in;
      neg_ff        <= neg_in;
      zero_ff       <= zero_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      hue_ff        <= hue_in;
      rd_addr_ff    <= rd_addr_in;
      s1_idx_ff     <= s1_idx_in;
      s2_idx_ff     <= s2_idx_in;
      s2_color_ff   <= s2_color_in;
      dist_ff       <= dist_in;
      best_dist_ff  <= best_dist_in;
      best_idx_ff   <= best_idx_in;
      best_color_ff <= best_color_in;
      rsp_item_ff   <= rsp_item_in;
   end

   // palette store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         color_mem[IDX_W'(item_ff.entry_index)] <= {item_ff.red, item_ff.green, item_ff.blue};
         hue_mem[IDX_W'(item_ff.entry_index)]   <= hue_in;
      end
      if (rd_en) begin
         color_rd_ff <= color_mem[rd_addr_ff];
         hue_rd_ff   <= hue_mem[rd_addr_ff];
      end
   end

   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while a command is still in progress");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.op == pncm_pkg::OP_LOAD) |=> !rsp_strobe)
      else $error("load command produced a result beat");

   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.empty_palette) |->
         (rsp_item.match_index == '0 && rsp_item.match_red == '0 &&
          rsp_item.match_green == '0 && rsp_item.match_blue == '0))
      else $error("empty palette result carries nonzero fields");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pncm_pkg::ST_DIVIDE) |-> (rem_ff < div_ff))
      else $error("hue divider remainder not below divisor");

endmodule
